[rtl/mtm_pkg.sv]
// ----------------------------------------------------------------------------
// mtm_pkg
// shared types and constants of the multirotor thrust mixer
// ----------------------------------------------------------------------------
package mtm_pkg;

	localparam int NUM_SLOTS = 4;
	localparam int TRI_UNUSED_SLOT = 1;

	// register map, word index
	localparam logic [1:0] REG_FRAME_TYPE   = 2'd0;
	localparam logic [1:0] REG_MIN_THROTTLE = 2'd1;
	localparam logic [1:0] REG_MAX_THROTTLE = 2'd2;

	localparam logic       FRAME_TRI        = 1'b0;
	localparam logic       RST_FRAME_TYPE   = 1'b1;
	localparam logic [11:0] RST_MIN_THROTTLE = 12'd1150;
	localparam logic [11:0] RST_MAX_THROTTLE = 12'd1850;

	localparam logic [3:0] MASK_TRI = 4'b1101;
	localparam logic [3:0] MASK_ALL = 4'b1111;

	// 3 * sqrt(3)/4 in q16
	localparam logic [16:0] TRI_SIDE_K = 17'd85134;
	// floor(t/3) = (t * DIV3_RECIP) >> 18, exact for t < 2^17
	localparam logic [16:0] DIV3_RECIP = 17'd87382;
	// commands saturate above this force for any throttle window
	localparam logic [10:0] FORCE_CAP  = 11'd2047;
	localparam logic [8:0]  CMD_GAIN   = 9'd283;
	// floor(n/25) = (n * DIV25_RECIP) >> 23, exact for n < 493447
	localparam logic [18:0] DIV25_RECIP = 19'd335545;
	localparam logic [12:0] CMD_OFFSET  = 13'd1274;

	typedef logic [10:0] force_t;
	typedef logic [12:0] cmd_t;

	typedef struct packed {
		logic off;
		logic tri_frame;
	} ctrl_t;

endpackage

[rtl/mtm_force.sv]
// ----------------------------------------------------------------------------
// mtm_force
// three-stage force split: numerators, dividends, divide and cap per slot
// ----------------------------------------------------------------------------
module mtm_force import mtm_pkg::*; (
	input  logic                        clk,
	input  logic                        en,
	input  logic                        motors_off,
	input  logic                        frame_type,
	input  logic signed [16:0]          total_force,
	input  logic signed [15:0]          diff_force_x,
	input  logic signed [15:0]          diff_force_y,
	output ctrl_t                       ctrl_s3,
	output force_t [NUM_SLOTS-1:0]      force_s3
);

	function automatic logic [17:0] quad_dividend(input logic signed [18:0] n);
		logic [17:0] r;
		r = (n[18] || n == 19'sd0) ? 18'd0 : {1'b0, n[18:2]};
		return r;
	endfunction

	function automatic logic [17:0] front_dividend(input logic signed [18:0] n);
		logic [17:0] r;
		r = (n[18] || n == 19'sd0) ? 18'd0 : n[17:0];
		return r;
	endfunction

	function automatic logic [17:0] tri_dividend(input logic signed [34:0] m);
		logic [17:0] r;
		r = (m[34] || m == 35'sd0) ? 18'd0 : m[33:16];
		return r;
	endfunction

	logic signed [18:0] f_ext, x2_ext, y2_ext;
	logic signed [33:0] side_c;

	ctrl_t                          ctrl_s1, ctrl_s2;
	logic signed [NUM_SLOTS-1:0][18:0] qnum_s1;
	logic signed [17:0]             base_s1;
	logic signed [33:0]             side_s1;

	logic signed [34:0]             base_ext, side_ext, m_rr, m_rl;
	logic [NUM_SLOTS-1:0][17:0]     dividend_c;
	logic [NUM_SLOTS-1:0][17:0]     dividend_s2;

	logic [NUM_SLOTS-1:0][34:0]     prod_c;
	force_t [NUM_SLOTS-1:0]         force_c;

	// stage 1: numerators and side product
	always_comb begin
		f_ext  = {{2{total_force[16]}}, total_force};
		x2_ext = {{2{diff_force_x[15]}}, diff_force_x, 1'b0};
		y2_ext = {{2{diff_force_y[15]}}, diff_force_y, 1'b0};
		side_c = $signed({{18{diff_force_x[15]}}, diff_force_x}) *
		         $signed({17'd0, TRI_SIDE_K});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s1.off       <= motors_off;
			ctrl_s1.tri_frame <= (frame_type == FRAME_TRI);
			qnum_s1[0]        <= f_ext + y2_ext;
			qnum_s1[1]        <= f_ext - x2_ext;
			qnum_s1[2]        <= f_ext + x2_ext;
			qnum_s1[3]        <= f_ext - y2_ext;
			base_s1           <= {total_force[16], total_force} +
			                     {{2{diff_force_y[15]}}, diff_force_y};
			side_s1           <= side_c;
		end
	end

	// stage 2: nonnegative dividends
	always_comb begin
		base_ext = {base_s1[17], base_s1, 16'd0};
		side_ext = {side_s1[33], side_s1};
		m_rr     = base_ext - side_ext;
		m_rl     = base_ext + side_ext;
		if (ctrl_s1.tri_frame) begin
			dividend_c[0] = tri_dividend(m_rr);
			dividend_c[1] = 18'd0;
			dividend_c[2] = tri_dividend(m_rl);
			dividend_c[3] = front_dividend(qnum_s1[3]);
		end else begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				dividend_c[i] = quad_dividend(qnum_s1[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s2     <= ctrl_s1;
			dividend_s2 <= dividend_c;
		end
	end

	// stage 3: divide by three for tri, cap
	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			logic [16:0] f;
			prod_c[i] = 35'(dividend_s2[i]) * 35'(DIV3_RECIP);
			f = ctrl_s2.tri_frame ? prod_c[i][34:18] : dividend_s2[i][16:0];
			force_c[i] = (f > 17'(FORCE_CAP)) ? FORCE_CAP : f[10:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s3  <= ctrl_s2;
			force_s3 <= force_c;
		end
	end

endmodule

[rtl/mtm_cmd.sv]
// ----------------------------------------------------------------------------
// mtm_cmd
// two-stage force to command map for one slot: f*283/100 + 1274
// ----------------------------------------------------------------------------
module mtm_cmd import mtm_pkg::*; (
	input  logic   clk,
	input  logic   en,
	input  force_t force_s3,
	output cmd_t   cmd_s5
);

	logic [19:0] scaled_s4;
	logic [36:0] quot_prod_c;

	always_ff @(posedge clk) begin
		if (en) begin
			scaled_s4 <= 20'(force_s3) * 20'(CMD_GAIN);
		end
	end

	// divide by 100 as a shift by two and a reciprocal of 25
	assign quot_prod_c = 37'(scaled_s4[19:2]) * 37'(DIV25_RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s5 <= quot_prod_c[35:23] + CMD_OFFSET;
		end
	end

endmodule

[rtl/multirotor_thrust_mixer.sv]
// ----------------------------------------------------------------------------
// multirotor_thrust_mixer
// pipeline: registered stages s1 to s6 from the accepted beat to the result beat
// throughput: one beat per cycle; the whole pipeline holds while the result stalls
// reset: valid bits clear, frame_type 1, min_throttle 1150, max_throttle 1850
// ----------------------------------------------------------------------------
module multirotor_thrust_mixer import mtm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               motors_off,
	input  logic signed [16:0] total_force,
	input  logic signed [15:0] diff_force_x,
	input  logic signed [15:0] diff_force_y,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [11:0]        slot0_command,
	output logic [11:0]        slot1_command,
	output logic [11:0]        slot2_command,
	output logic [11:0]        slot3_command,
	output logic [3:0]         written_mask
);

	logic        frame_type_q;
	logic [11:0] min_throttle_q, max_throttle_q;
	logic        advance;
	logic        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;

	ctrl_t                     ctrl_s3, ctrl_s4, ctrl_s5;
	force_t [NUM_SLOTS-1:0]    force_s3;
	cmd_t   [NUM_SLOTS-1:0]    cmd_s5;
	logic   [NUM_SLOTS-1:0][11:0] cmd_c, cmd_s6;
	logic   [3:0]              mask_c, mask_s6;

	// config port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_type_q   <= RST_FRAME_TYPE;
			min_throttle_q <= RST_MIN_THROTTLE;
			max_throttle_q <= RST_MAX_THROTTLE;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_FRAME_TYPE:   frame_type_q   <= pwdata[0];
				REG_MIN_THROTTLE: min_throttle_q <= pwdata[11:0];
				REG_MAX_THROTTLE: max_throttle_q <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_FRAME_TYPE:   prdata = {31'd0, frame_type_q};
			REG_MIN_THROTTLE: prdata = {20'd0, min_throttle_q};
			REG_MAX_THROTTLE: prdata = {20'd0, max_throttle_q};
			default:          prdata = 32'd0;
		endcase
	end

	// pipeline control
	assign advance    = !valid_s6 || !result_stall;
	assign item_stall = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= item_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	mtm_force u_force (
		.clk          (clk),
		.en           (advance),
		.motors_off   (motors_off),
		.frame_type   (frame_type_q),
		.total_force  (total_force),
		.diff_force_x (diff_force_x),
		.diff_force_y (diff_force_y),
		.ctrl_s3      (ctrl_s3),
		.force_s3     (force_s3)
	);

	for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_slot
		mtm_cmd u_cmd (
			.clk      (clk),
			.en       (advance),
			.force_s3 (force_s3[g]),
			.cmd_s5   (cmd_s5[g])
		);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ctrl_s4 <= ctrl_s3;
			ctrl_s5 <= ctrl_s4;
		end
	end

	// stage 6: throttle window, off and unused slot
	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			logic [11:0] c;
			c = (cmd_s5[i] > {1'b0, max_throttle_q}) ? max_throttle_q : cmd_s5[i][11:0];
			if (c < min_throttle_q) begin
				c = min_throttle_q;
			end
			if (ctrl_s5.off) begin
				cmd_c[i] = min_throttle_q;
			end else if (ctrl_s5.tri_frame && i == TRI_UNUSED_SLOT) begin
				cmd_c[i] = 12'd0;
			end else begin
				cmd_c[i] = c;
			end
		end
		mask_c = (ctrl_s5.tri_frame && !ctrl_s5.off) ? MASK_TRI : MASK_ALL;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_s6  <= cmd_c;
			mask_s6 <= mask_c;
		end
	end

	assign result_valid  = valid_s6;
	assign slot0_command = cmd_s6[0];
	assign slot1_command = cmd_s6[1];
	assign slot2_command = cmd_s6[2];
	assign slot3_command = cmd_s6[3];
	assign written_mask  = mask_s6;

endmodule
